[rtl/gbn_pkg.sv]
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, codes and small tables of the go-back-n endpoint.
// ----------------------------------------------------------------------------
package gbn_pkg;

   // event opcodes
   localparam logic [3:0] OP_SEND_DATA = 4'd0;
   localparam logic [3:0] OP_SEND_END  = 4'd1;
   localparam logic [3:0] OP_RX_DATA   = 4'd2;
   localparam logic [3:0] OP_RX_ACK    = 4'd3;
   localparam logic [3:0] OP_RX_SYN    = 4'd4;
   localparam logic [3:0] OP_RX_FIN    = 4'd5;
   localparam logic [3:0] OP_RX_RST    = 4'd6;
   localparam logic [3:0] OP_TICK      = 4'd7;
   localparam logic [3:0] OP_STALE     = 4'd8;

   // result actions
   localparam logic [1:0] ACT_TX      = 2'd0;
   localparam logic [1:0] ACT_DELIVER = 2'd1;
   localparam logic [1:0] ACT_DROP    = 2'd2;
   localparam logic [1:0] ACT_ERROR   = 2'd3;

   // frame types
   localparam logic [2:0] FT_DATA = 3'd0;
   localparam logic [2:0] FT_ACK  = 3'd1;
   localparam logic [2:0] FT_SYN  = 3'd2;
   localparam logic [2:0] FT_FIN  = 3'd3;
   localparam logic [2:0] FT_RST  = 3'd4;

   // flow status codes
   localparam logic [1:0] FS_VALID = 2'd0;
   localparam logic [1:0] FS_ENDED = 2'd1;

   // register indexes
   localparam logic [2:0] CSR_WINDOW     = 3'd0;
   localparam logic [2:0] CSR_RETRY_LIM  = 3'd1;
   localparam logic [2:0] CSR_RETRY_BASE = 3'd2;
   localparam logic [2:0] CSR_ACK_DELAY  = 3'd3;
   localparam logic [2:0] CSR_INIT_SEQ   = 3'd4;

   // register reset values
   localparam logic [6:0]  WINDOW_RST     = 7'd64;
   localparam logic [3:0]  RETRY_LIM_RST  = 4'd10;
   localparam logic [15:0] RETRY_BASE_RST = 16'd200;
   localparam logic [15:0] ACK_DELAY_RST  = 16'd10;
   localparam logic [15:0] INIT_SEQ_RST   = 16'd0;

   typedef enum logic [2:0] {
      PH_NONE = 3'd0,
      PH_SYN  = 3'd1,
      PH_RDY  = 3'd2,
      PH_FIN  = 3'd3,
      PH_ERR  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      WALK_NONE,
      WALK_PUMP,
      WALK_RESEND
   } walk_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_UPD,
      ST_FIX0,
      ST_FIX1,
      ST_WALK_CHK,
      ST_WALK_RD,
      ST_WALK_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]  act;
      logic [2:0]  ftype;
      logic [15:0] seq;
      logic [15:0] hdl;
      logic        eos;
   } rslt_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic upd;
      logic emit_fix0;
      logic emit_fix1;
      logic walk_rd;
      logic walk_emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] fix_cnt;
      logic       walk_avail;
      logic       out_free;
   } status_type;

   function automatic rslt_type mk_rslt(input logic [1:0] act, input logic [2:0] ftype,
                                        input logic [15:0] seq, input logic [15:0] hdl,
                                        input logic eos);
      rslt_type r;
      r.act   = act;
      r.ftype = ftype;
      r.seq   = seq;
      r.hdl   = hdl;
      r.eos   = eos;
      return r;
   endfunction

   // square of the retry count
   function automatic logic [7:0] retry_square(input logic [3:0] c);
      logic [7:0] s;
      case (c)
         4'd0:    s = 8'd0;
         4'd1:    s = 8'd1;
         4'd2:    s = 8'd4;
         4'd3:    s = 8'd9;
         4'd4:    s = 8'd16;
         4'd5:    s = 8'd25;
         4'd6:    s = 8'd36;
         4'd7:    s = 8'd49;
         4'd8:    s = 8'd64;
         4'd9:    s = 8'd81;
         4'd10:   s = 8'd100;
         4'd11:   s = 8'd121;
         4'd12:   s = 8'd144;
         4'd13:   s = 8'd169;
         4'd14:   s = 8'd196;
         default: s = 8'd225;
      endcase
      return s;
   endfunction

endpackage

[rtl/gbn_ctrl.sv]
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer of the endpoint: event, update, fixed results, ring walk.
// ----------------------------------------------------------------------------
module gbn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  gbn_pkg::status_type status,
   output gbn_pkg::cmd_type    cmd
);

   gbn_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         gbn_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = gbn_pkg::ST_EXEC;
            end
         end
         gbn_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = gbn_pkg::ST_UPD;
         end
         gbn_pkg::ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = (status.fix_cnt != 2'd0) ? gbn_pkg::ST_FIX0 : gbn_pkg::ST_WALK_CHK;
         end
         gbn_pkg::ST_FIX0: begin
            if (status.out_free) begin
               cmd.emit_fix0 = 1'b1;
               state_in = (status.fix_cnt == 2'd2) ? gbn_pkg::ST_FIX1 : gbn_pkg::ST_IDLE;
            end
         end
         gbn_pkg::ST_FIX1: begin
            if (status.out_free) begin
               cmd.emit_fix1 = 1'b1;
               state_in      = gbn_pkg::ST_IDLE;
            end
         end
         gbn_pkg::ST_WALK_CHK: begin
            state_in = status.walk_avail ? gbn_pkg::ST_WALK_RD : gbn_pkg::ST_IDLE;
         end
         gbn_pkg::ST_WALK_RD: begin
            cmd.walk_rd = 1'b1;
            state_in    = gbn_pkg::ST_WALK_OUT;
         end
         gbn_pkg::ST_WALK_OUT: begin
            if (status.out_free) begin
               cmd.walk_emit = 1'b1;
               state_in      = gbn_pkg::ST_WALK_CHK;
            end
         end
         default: begin
            state_in = gbn_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/gbn_dp.sv]
// ----------------------------------------------------------------------------
// gbn_dp
// Flow state, frame ring, retry and ack timers, result register.
// ----------------------------------------------------------------------------
module gbn_dp #(
   parameter int SEQ_BITS     = 16,
   parameter int WINDOW_LIMIT = 64,
   parameter int QUEUE_DEPTH  = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  gbn_pkg::cmd_type    cmd,
   output gbn_pkg::status_type status,
   input  logic [3:0]          req_opcode,
   input  logic [15:0]         req_seq,
   input  logic [15:0]         req_handle,
   input  logic [1:0]          req_flow_status,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gbn_pkg::rslt_type   rsp_rslt,
   output logic                rsp_last
);

   localparam int IDXW = $clog2(QUEUE_DEPTH);
   localparam int IFW  = $clog2(WINDOW_LIMIT + 1);
   localparam int WW   = $clog2(QUEUE_DEPTH + 1);
   localparam int UW   = WW + 1;

   // configuration
   logic [6:0]  win_ff;
   logic [3:0]  rlim_ff;
   logic [15:0] rbase_ff, adly_ff, iseq_ff;

   // captured event
   logic [3:0]          op_ff;
   logic [SEQ_BITS-1:0] seq_ff;
   logic [15:0]         hdl_ff;
   logic [1:0]          fs_ff;

   // flow state
   logic                open_ff, open_in;
   gbn_pkg::phase_type  lph_ff, lph_in, rph_ff, rph_in;
   logic [SEQ_BITS-1:0] acked_ff, acked_in, rseq_ff, rseq_in;
   logic [IDXW-1:0]     head_ff, head_in;
   logic [IFW-1:0]      infl_ff, infl_in;
   logic [WW-1:0]       wait_ff, wait_in;
   logic [3:0]          rcnt_ff, rcnt_in;
   logic [31:0]         relap_ff, relap_in, rtmo_ff, rtmo_in;
   logic                apend_ff, apend_in;
   logic [15:0]         aelap_ff, aelap_in;

   // plan of the current event
   logic [1:0]          fixn_ff, fixn_in;
   gbn_pkg::rslt_type   fix0_ff, fix0_in, fix1_ff, fix1_in;
   gbn_pkg::walk_type   walk_ff, walk_in;
   logic                push1_ff, push1_in, tmold_ff, tmold_in;
   logic [IFW-1:0]      wpos_ff;

   // frame ring
   logic [18:0] ring [QUEUE_DEPTH];
   logic [18:0] rd_ff;
   logic        wr0_en, wr_en;
   logic [IDXW-1:0] wr0_addr, wr_addr, rd_addr, push_addr;
   logic [18:0] wr0_data, wr_data;

   // result register
   logic              ov_ff;
   gbn_pkg::rslt_type orslt_ff;
   logic              olast_ff;

   logic [UW-1:0]       used;
   logic                full, cs, pump_avail;
   logic [6:0]          weff;
   logic [IFW-1:0]      wp;
   gbn_pkg::rslt_type   drop_r, rst_r, err_r, walk_r;
   logic                walk_last;
   logic [SEQ_BITS+15:0] seq_ext;

   function automatic logic [IDXW-1:0] wrap_idx(input logic [IDXW:0] s);
      logic [IDXW:0] t;
      t = (s >= (IDXW+1)'(QUEUE_DEPTH)) ? s - (IDXW+1)'(QUEUE_DEPTH) : s;
      return t[IDXW-1:0];
   endfunction

   function automatic logic [15:0] to16(input logic [SEQ_BITS-1:0] v);
      logic [SEQ_BITS+15:0] t;
      t = {16'd0, v};
      return t[15:0];
   endfunction

   function automatic logic [SEQ_BITS-1:0] from16(input logic [15:0] v);
      logic [SEQ_BITS+15:0] t;
      t = {{SEQ_BITS{1'b0}}, v};
      return t[SEQ_BITS-1:0];
   endfunction

   assign seq_ext    = {{SEQ_BITS{1'b0}}, req_seq};
   assign used       = UW'(infl_ff) + UW'(wait_ff);
   assign full       = used >= UW'(QUEUE_DEPTH);
   assign push_addr  = wrap_idx({1'b0, head_ff} + used[IDXW:0]);
   assign cs         = (lph_ff == gbn_pkg::PH_SYN) || (lph_ff == gbn_pkg::PH_RDY) ||
                       (lph_ff == gbn_pkg::PH_FIN);
   assign weff       = (win_ff == 7'd0) ? 7'd1 :
                       (win_ff > 7'(WINDOW_LIMIT)) ? 7'(WINDOW_LIMIT) : win_ff;
   assign pump_avail = (7'(infl_ff) < weff) && (wait_ff != '0) && cs;

   assign drop_r = gbn_pkg::mk_rslt(gbn_pkg::ACT_DROP, gbn_pkg::FT_DATA, to16(seq_ff),
                                    hdl_ff, 1'b0);
   assign rst_r  = gbn_pkg::mk_rslt(gbn_pkg::ACT_TX, gbn_pkg::FT_RST, 16'd0, 16'd0, 1'b0);
   assign err_r  = gbn_pkg::mk_rslt(gbn_pkg::ACT_ERROR, gbn_pkg::FT_DATA, 16'd0, 16'd0, 1'b0);

   // ring walk: pump sends from the flight edge, resend from the head
   assign wp      = (walk_ff == gbn_pkg::WALK_PUMP) ? infl_ff : wpos_ff;
   assign rd_addr = wrap_idx({1'b0, head_ff} + (IDXW+1)'(wp));
   assign walk_r  = gbn_pkg::mk_rslt(gbn_pkg::ACT_TX, rd_ff[18:16],
                       to16(acked_ff + SEQ_BITS'(1) + SEQ_BITS'(wp)), rd_ff[15:0], 1'b0);
   assign walk_last = (walk_ff == gbn_pkg::WALK_PUMP) ?
                      !((7'(infl_ff) + 7'd1 < weff) && (wait_ff > WW'(1))) :
                      (wpos_ff == infl_ff - IFW'(1));

   assign status.fix_cnt    = fixn_ff;
   assign status.walk_avail = (walk_ff == gbn_pkg::WALK_PUMP)   ? pump_avail :
                              (walk_ff == gbn_pkg::WALK_RESEND) ? (wpos_ff < infl_ff) : 1'b0;
   assign status.out_free   = !ov_ff || rsp_ready;

   // event decision
   always_comb begin : exec_logic
      logic [SEQ_BITS-1:0] d, dr, rnext;
      logic                gt_ack, gt_rem, fired, do_rs;
      logic [15:0]         ae;
      logic [31:0]         re;
      logic [IFW-1:0]      ds;
      d      = seq_ff - acked_ff;
      dr     = rseq_ff - seq_ff;
      rnext  = rseq_ff + SEQ_BITS'(1);
      gt_ack = (d != '0) && !d[SEQ_BITS-1];
      gt_rem = (dr != '0) && !dr[SEQ_BITS-1];
      ds     = d[IFW-1:0];
      fired  = 1'b0;
      do_rs  = 1'b0;
      ae     = (aelap_ff == 16'hFFFF) ? aelap_ff : aelap_ff + 16'd1;
      re     = (relap_ff == 32'hFFFF_FFFF) ? relap_ff : relap_ff + 32'd1;

      open_in  = open_ff;
      lph_in   = lph_ff;
      rph_in   = rph_ff;
      acked_in = acked_ff;
      rseq_in  = rseq_ff;
      head_in  = head_ff;
      infl_in  = infl_ff;
      wait_in  = wait_ff;
      rcnt_in  = rcnt_ff;
      relap_in = relap_ff;
      rtmo_in  = rtmo_ff;
      apend_in = apend_ff;
      aelap_in = aelap_ff;
      fixn_in  = 2'd0;
      fix0_in  = drop_r;
      fix1_in  = drop_r;
      walk_in  = gbn_pkg::WALK_NONE;
      push1_in = 1'b0;
      tmold_in = 1'b0;
      wr0_en   = 1'b0;
      wr0_addr = push_addr;
      wr0_data = {gbn_pkg::FT_DATA, hdl_ff};

      case (op_ff)
         gbn_pkg::OP_SEND_DATA: begin
            if (!open_ff || lph_ff == gbn_pkg::PH_NONE) begin
               // new or idle flow: open with a syn, then the data frame
               open_in  = 1'b1;
               if (!open_ff) begin
                  acked_in = from16(iseq_ff);
                  rph_in   = gbn_pkg::PH_NONE;
                  head_in  = '0;
                  rcnt_in  = 4'd0;
                  relap_in = 32'd0;
                  rtmo_in  = 32'd0;
                  apend_in = 1'b0;
                  aelap_in = 16'd0;
               end
               lph_in   = gbn_pkg::PH_SYN;
               infl_in  = '0;
               wait_in  = WW'(2);
               wr0_en   = 1'b1;
               wr0_addr = open_ff ? head_ff : '0;
               wr0_data = {gbn_pkg::FT_SYN, 16'd0};
               push1_in = 1'b1;
               walk_in  = gbn_pkg::WALK_PUMP;
            end else if (full) begin
               fixn_in = 2'd1;
            end else begin
               wr0_en  = 1'b1;
               wait_in = wait_ff + WW'(1);
               walk_in = gbn_pkg::WALK_PUMP;
            end
         end
         gbn_pkg::OP_SEND_END: begin
            if (!open_ff) begin
               fixn_in = 2'd1;
            end else if (lph_ff == gbn_pkg::PH_RDY || lph_ff == gbn_pkg::PH_SYN) begin
               if (full) begin
                  fixn_in = 2'd1;
               end else begin
                  wr0_en   = 1'b1;
                  wr0_data = {gbn_pkg::FT_FIN, 16'd0};
                  wait_in  = wait_ff + WW'(1);
                  lph_in   = gbn_pkg::PH_FIN;
                  walk_in  = gbn_pkg::WALK_PUMP;
               end
            end else begin
               // end marker passed through
               fixn_in = 2'd1;
               fix0_in = gbn_pkg::mk_rslt(gbn_pkg::ACT_TX, gbn_pkg::FT_DATA, 16'd0,
                                          hdl_ff, 1'b1);
            end
         end
         gbn_pkg::OP_RX_DATA: begin
            if (!open_ff) begin
               fixn_in = 2'd1;
            end else if (fs_ff != gbn_pkg::FS_VALID || rph_ff != gbn_pkg::PH_RDY) begin
               if (rph_ff == gbn_pkg::PH_ERR || fs_ff == gbn_pkg::FS_ENDED) begin
                  fixn_in = 2'd2;
                  fix0_in = rst_r;
               end else begin
                  fixn_in = 2'd1;
               end
            end else begin
               fixn_in = 2'd1;
               if (seq_ff == rnext) begin
                  fix0_in = gbn_pkg::mk_rslt(gbn_pkg::ACT_DELIVER, gbn_pkg::FT_DATA,
                                             to16(seq_ff), hdl_ff, 1'b0);
                  rseq_in = seq_ff;
               end
               if (!apend_ff) begin
                  apend_in = 1'b1;
                  aelap_in = 16'd0;
               end
            end
         end
         gbn_pkg::OP_RX_ACK: begin
            if (!open_ff || lph_ff == gbn_pkg::PH_NONE) begin
               fixn_in = 2'd1;
            end else if (lph_ff == gbn_pkg::PH_ERR) begin
               fixn_in = 2'd2;
               fix0_in = rst_r;
            end else if (gt_ack) begin
               if (d > SEQ_BITS'(infl_ff)) begin
                  fixn_in = 2'd1;
               end else begin
                  if (lph_ff == gbn_pkg::PH_SYN) lph_in = gbn_pkg::PH_RDY;
                  rcnt_in  = 4'd0;
                  rtmo_in  = 32'(rbase_ff);
                  relap_in = 32'd0;
                  acked_in = seq_ff;
                  head_in  = wrap_idx({1'b0, head_ff} + (IDXW+1)'(ds));
                  infl_in  = infl_ff - ds;
                  walk_in  = gbn_pkg::WALK_PUMP;
               end
            end else begin
               do_rs = 1'b1;
            end
         end
         gbn_pkg::OP_RX_SYN: begin
            if (!open_ff || rph_ff == gbn_pkg::PH_NONE) begin
               if (!open_ff) begin
                  open_in  = 1'b1;
                  acked_in = from16(iseq_ff);
                  lph_in   = gbn_pkg::PH_NONE;
                  head_in  = '0;
                  infl_in  = '0;
                  wait_in  = '0;
                  rcnt_in  = 4'd0;
                  relap_in = 32'd0;
                  rtmo_in  = 32'd0;
                  apend_in = 1'b0;
                  aelap_in = 16'd0;
               end
               rseq_in = seq_ff;
               rph_in  = gbn_pkg::PH_RDY;
               fixn_in = 2'd1;
               fix0_in = gbn_pkg::mk_rslt(gbn_pkg::ACT_TX, gbn_pkg::FT_ACK, to16(seq_ff),
                                          16'd0, 1'b0);
            end else if ((rph_ff == gbn_pkg::PH_RDY || rph_ff == gbn_pkg::PH_FIN) &&
                         (rseq_ff == seq_ff || gt_rem)) begin
               // duplicate syn
               fixn_in = 2'd0;
            end else begin
               fixn_in = 2'd1;
               fix0_in = rst_r;
            end
         end
         gbn_pkg::OP_RX_FIN: begin
            fixn_in = 2'd1;
            if (!open_ff) begin
               fix0_in = rst_r;
            end else begin
               if (seq_ff == rnext) begin
                  rseq_in = seq_ff;
                  rph_in  = gbn_pkg::PH_FIN;
                  if (fs_ff == gbn_pkg::FS_VALID) begin
                     fix0_in = gbn_pkg::mk_rslt(gbn_pkg::ACT_DELIVER, gbn_pkg::FT_FIN,
                                                to16(seq_ff), hdl_ff, 1'b1);
                  end
               end
               if (!apend_ff) begin
                  apend_in = 1'b1;
                  aelap_in = 16'd0;
               end
            end
         end
         gbn_pkg::OP_RX_RST: begin
            if (open_ff) begin
               lph_in  = gbn_pkg::PH_ERR;
               rph_in  = gbn_pkg::PH_ERR;
               infl_in = '0;
               wait_in = '0;
            end
            fixn_in = 2'd1;
            fix0_in = err_r;
         end
         gbn_pkg::OP_TICK: begin
            if (apend_ff) begin
               aelap_in = ae;
               if (ae >= adly_ff) begin
                  fixn_in  = 2'd1;
                  fix0_in  = gbn_pkg::mk_rslt(gbn_pkg::ACT_TX, gbn_pkg::FT_ACK,
                                              to16(rseq_ff), 16'd0, 1'b0);
                  apend_in = 1'b0;
                  fired    = 1'b1;
               end
            end
            if (open_ff && lph_ff != gbn_pkg::PH_NONE && lph_ff != gbn_pkg::PH_ERR &&
                infl_ff != '0) begin
               relap_in = re;
               if (!fired && re > rtmo_ff) begin
                  do_rs    = 1'b1;
                  relap_in = 32'd0;
               end
            end
         end
         gbn_pkg::OP_STALE: begin
            if (open_ff && (lph_ff == gbn_pkg::PH_SYN || lph_ff == gbn_pkg::PH_RDY ||
                            rph_ff == gbn_pkg::PH_RDY)) begin
               fixn_in  = 2'd1;
               fix0_in  = rst_r;
               lph_in   = gbn_pkg::PH_ERR;
               rph_in   = gbn_pkg::PH_ERR;
               infl_in  = '0;
               wait_in  = '0;
               apend_in = 1'b0;
            end
         end
         default: begin
            fixn_in = 2'd0;
         end
      endcase

      // resend of the whole flight, or flow error once retries run out
      if (do_rs) begin
         if (rcnt_ff < rlim_ff) begin
            if (cs && infl_ff != '0) begin
               walk_in  = gbn_pkg::WALK_RESEND;
               rcnt_in  = (rcnt_ff == 4'd15) ? rcnt_ff : rcnt_ff + 4'd1;
               relap_in = 32'd0;
               tmold_in = 1'b1;
            end
         end else begin
            infl_in = '0;
            wait_in = '0;
            lph_in  = gbn_pkg::PH_ERR;
            fixn_in = 2'd1;
            fix0_in = err_r;
         end
      end
   end

   assign wr_en   = (cmd.exec && wr0_en) || (cmd.upd && push1_ff);
   assign wr_addr = cmd.exec ? wr0_addr : wrap_idx({1'b0, head_ff} + (IDXW+1)'(1));
   assign wr_data = cmd.exec ? wr0_data : {gbn_pkg::FT_DATA, hdl_ff};

   always_ff @(posedge clock) begin
      if (wr_en) ring[wr_addr] <= wr_data;
      if (cmd.walk_rd) rd_ff <= ring[rd_addr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         seq_ff <= seq_ext[SEQ_BITS-1:0];
         hdl_ff <= req_handle;
         fs_ff  <= req_flow_status;
      end
      if (cmd.exec) begin
         fix0_ff <= fix0_in;
         fix1_ff <= fix1_in;
      end
      if (cmd.emit_fix0) begin
         orslt_ff <= fix0_ff;
         olast_ff <= (fixn_ff == 2'd1);
      end else if (cmd.emit_fix1) begin
         orslt_ff <= fix1_ff;
         olast_ff <= 1'b1;
      end else if (cmd.walk_emit) begin
         orslt_ff <= walk_r;
         olast_ff <= walk_last;
      end
   end

   // control and flow state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= gbn_pkg::WINDOW_RST;
         rlim_ff  <= gbn_pkg::RETRY_LIM_RST;
         rbase_ff <= gbn_pkg::RETRY_BASE_RST;
         adly_ff  <= gbn_pkg::ACK_DELAY_RST;
         iseq_ff  <= gbn_pkg::INIT_SEQ_RST;
         open_ff  <= 1'b0;
         lph_ff   <= gbn_pkg::PH_NONE;
         rph_ff   <= gbn_pkg::PH_NONE;
         acked_ff <= '0;
         rseq_ff  <= '0;
         head_ff  <= '0;
         infl_ff  <= '0;
         wait_ff  <= '0;
         rcnt_ff  <= 4'd0;
         relap_ff <= 32'd0;
         rtmo_ff  <= 32'd0;
         apend_ff <= 1'b0;
         aelap_ff <= 16'd0;
         fixn_ff  <= 2'd0;
         walk_ff  <= gbn_pkg::WALK_NONE;
         push1_ff <= 1'b0;
         tmold_ff <= 1'b0;
         wpos_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               gbn_pkg::CSR_WINDOW:     win_ff   <= csr_wdata[6:0];
               gbn_pkg::CSR_RETRY_LIM:  rlim_ff  <= csr_wdata[3:0];
               gbn_pkg::CSR_RETRY_BASE: rbase_ff <= csr_wdata;
               gbn_pkg::CSR_ACK_DELAY:  adly_ff  <= csr_wdata;
               gbn_pkg::CSR_INIT_SEQ:   iseq_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.exec) begin
            open_ff  <= open_in;
            lph_ff   <= lph_in;
            rph_ff   <= rph_in;
            acked_ff <= acked_in;
            rseq_ff  <= rseq_in;
            head_ff  <= head_in;
            infl_ff  <= infl_in;
            wait_ff  <= wait_in;
            rcnt_ff  <= rcnt_in;
            relap_ff <= relap_in;
            rtmo_ff  <= rtmo_in;
            apend_ff <= apend_in;
            aelap_ff <= aelap_in;
            fixn_ff  <= fixn_in;
            walk_ff  <= walk_in;
            push1_ff <= push1_in;
            tmold_ff <= tmold_in;
            wpos_ff  <= '0;
         end
         // timeout grows with the square of the retry count
         if (cmd.upd && tmold_ff) begin
            rtmo_ff <= 32'(rbase_ff * gbn_pkg::retry_square(rcnt_ff));
         end
         if (cmd.walk_emit) begin
            if (walk_ff == gbn_pkg::WALK_PUMP) begin
               infl_ff <= infl_ff + IFW'(1);
               wait_ff <= wait_ff - WW'(1);
               if (infl_ff == '0) begin
                  rcnt_ff  <= 4'd0;
                  rtmo_ff  <= 32'(rbase_ff);
                  relap_ff <= 32'd0;
               end
            end else begin
               wpos_ff <= wpos_ff + IFW'(1);
            end
         end
         if (cmd.emit_fix0 || cmd.emit_fix1 || cmd.walk_emit) begin
            ov_ff <= 1'b1;
         end else if (rsp_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_rslt  = orslt_ff;
   assign rsp_last  = olast_ff;

endmodule

[rtl/go_back_n_arq_endpoint.sv]
// ----------------------------------------------------------------------------
// go_back_n_arq_endpoint
// Go-back-n sender and in-order receiver for one flow.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            contents
//  req      in         req_tvalid/tready    one event: send, rx frame, tick, stale
//  rsp      out        rsp_tvalid/tready    results of an event, rsp_tlast on the last
//  csr      in         csr_we               register write, index and data
//
//  an event passes through capture, decide and update; then each fixed result is
//  emitted, and frames taken from the ring go one at a time through check, read, emit
//  reset is synchronous and leaves the flow closed; the ring needs no clearing
//  a stalled rsp holds the sequencer; a new event is taken only once the last
//  result of the previous one is in the output register
//
module go_back_n_arq_endpoint #(
   parameter int SEQ_BITS     = 16,
   parameter int WINDOW_LIMIT = 64,
   parameter int QUEUE_DEPTH  = 128
) (
   input  logic        clock,
   input  logic        reset,
   // event transaction
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // seq_number[15:0], handle[31:16], flow_status[33:32]
   input  logic [3:0]  req_tuser,   // opcode[3:0]
   // result transaction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // frame_seq[15:0], frame_handle[31:16], end_of_stream[32]
   output logic [4:0]  rsp_tuser,   // action[1:0], frame_type[4:2]
   output logic        rsp_tlast,
   // register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   gbn_pkg::cmd_type    cmd;
   gbn_pkg::status_type status;
   gbn_pkg::rslt_type   rslt;

   // sequencer
   gbn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // flow state, ring and output register
   gbn_dp #(
      .SEQ_BITS     (SEQ_BITS),
      .WINDOW_LIMIT (WINDOW_LIMIT),
      .QUEUE_DEPTH  (QUEUE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_tuser),
      .req_seq         (req_tdata[15:0]),
      .req_handle      (req_tdata[31:16]),
      .req_flow_status (req_tdata[33:32]),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_rslt        (rslt),
      .rsp_last        (rsp_tlast)
   );

   // result packing, zero pad to whole bytes
   assign rsp_tdata = {7'd0, rslt.eos, rslt.hdl, rslt.seq};
   assign rsp_tuser = {rslt.ftype, rslt.act};

endmodule

[sim/tb_go_back_n_arq_endpoint.sv]
// ----------------------------------------------------------------------------
// tb_go_back_n_arq_endpoint
// Self-checking bench for the go-back-n endpoint: a directed table, then
// random event streams under several register settings, each transaction
// checked against a cycle-free model of the flow state kept in the bench.
// ----------------------------------------------------------------------------
module tb_go_back_n_arq_endpoint;
   import gbn_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN       = 400;   // margin for a full resend burst of up to 64 frames
   localparam int RING        = 128;
   localparam int WIN_MAX     = 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   go_back_n_arq_endpoint u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct {
      rslt_type r;
      logic     last;
   } outcome_t;

   typedef struct {
      logic [3:0]  op;
      logic [15:0] seq;
      logic [15:0] hdl;
      logic [1:0]  fs;
      bit          typed;   // expected result written in the row
      rslt_type    want;
   } row_t;

   // expected results, oldest first
   outcome_t expected_q[$];

   // register copies
   logic [6:0]  win_reg;
   logic [3:0]  rlim_reg;
   logic [15:0] rbase_reg, adly_reg, iseq_reg;

   // flow state copies
   bit          flow_up;
   phase_type   loc_ph, rem_ph;
   logic [15:0] next_seq, acked, rem_seq;
   logic [18:0] ring [RING];
   int          head, in_flight, queued;
   logic [3:0]  rcount;
   logic [31:0] relapsed, rtimeout;
   bit          ack_due;
   logic [15:0] ack_elapsed;

   int  errors = 0;
   int  cycles = 0;
   int  n_events = 0;
   int  n_results = 0;
   bit  calm = 0;     // no idling on either side
   bit  noisy = 0;

   outcome_t step_q[$];

   // ---------------------------------------------------------------- model
   function automatic void put(logic [1:0] a, logic [2:0] t, logic [15:0] s,
                               logic [15:0] h, logic e);
      outcome_t o;
      if (step_q.size() >= 64) return;
      o.r.act = a; o.r.ftype = t; o.r.seq = s; o.r.hdl = h; o.r.eos = e;
      o.last = 1'b0;
      step_q.push_back(o);
   endfunction

   function automatic bit seq_newer(logic [15:0] a, logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      return d != 0 && d < 16'h8000;
   endfunction

   function automatic bit sending();
      return loc_ph == PH_RDY || loc_ph == PH_SYN || loc_ph == PH_FIN;
   endfunction

   function automatic void timer_restart();
      rcount = 0; rtimeout = 32'(rbase_reg); relapsed = 0;
   endfunction

   function automatic void put_entry(int p);
      logic [18:0] e;
      e = ring[(head + p) % RING];
      put(ACT_TX, e[18:16], acked + 16'd1 + 16'(p), e[15:0], 1'b0);
   endfunction

   function automatic bit enqueue(logic [2:0] t, logic [15:0] h);
      if (in_flight + queued >= RING) return 0;
      ring[(head + in_flight + queued) % RING] = {t, h};
      queued++;
      next_seq = next_seq + 16'd1;
      return 1;
   endfunction

   function automatic void launch();
      int w, was, sent;
      w = (win_reg == 0) ? 1 : (win_reg > WIN_MAX) ? WIN_MAX : int'(win_reg);
      was = in_flight;
      sent = 0;
      while (in_flight < w && queued > 0 && sending()) begin
         put_entry(in_flight);
         in_flight++; queued--; sent++;
      end
      if (sent > 0 && was == 0) timer_restart();
   endfunction

   function automatic void go_back();
      if (rcount < rlim_reg) begin
         if (sending() && in_flight > 0) begin
            for (int p = 0; p < in_flight; p++) put_entry(p);
            if (rcount < 4'd15) rcount++;
            relapsed = 0;
            rtimeout = 32'(rbase_reg) * 32'(rcount) * 32'(rcount);
         end
      end else begin
         in_flight = 0; queued = 0;
         loc_ph = PH_ERR;
         put(ACT_ERROR, FT_DATA, 0, 0, 0);
      end
   endfunction

   function automatic void flow_open();
      flow_up = 1; acked = iseq_reg; next_seq = iseq_reg + 16'd1;
      loc_ph = PH_NONE; rem_ph = PH_NONE; head = 0; in_flight = 0; queued = 0;
      rcount = 0; relapsed = 0; rtimeout = 0; ack_due = 0; ack_elapsed = 0;
   endfunction

   function automatic void arm_ack();
      if (!ack_due) begin
         ack_due = 1; ack_elapsed = 0;
      end
   endfunction

   // works out the results of one event and advances the flow state
   function automatic void endpoint_step(logic [3:0] op, logic [15:0] seq,
                                         logic [15:0] h, logic [1:0] fs);
      logic [15:0] d;
      bit fired;
      step_q.delete();
      case (op)
         OP_SEND_DATA: begin
            if (!flow_up) flow_open();
            if (loc_ph == PH_NONE) begin
               loc_ph = PH_SYN;
               void'(enqueue(FT_SYN, 0));
               launch();
            end
            if (enqueue(FT_DATA, h)) launch();
            else put(ACT_DROP, FT_DATA, seq, h, 0);
         end
         OP_SEND_END: begin
            if (!flow_up) put(ACT_DROP, FT_DATA, seq, h, 0);
            else if (loc_ph == PH_RDY || loc_ph == PH_SYN) begin
               if (enqueue(FT_FIN, 0)) begin
                  loc_ph = PH_FIN;
                  launch();
               end else put(ACT_DROP, FT_DATA, seq, h, 0);
            end else put(ACT_TX, FT_DATA, 0, h, 1);
         end
         OP_RX_DATA: begin
            if (!flow_up) put(ACT_DROP, FT_DATA, seq, h, 0);
            else if (fs != FS_VALID || rem_ph != PH_RDY) begin
               if (rem_ph == PH_ERR || fs == FS_ENDED) put(ACT_TX, FT_RST, 0, 0, 0);
               put(ACT_DROP, FT_DATA, seq, h, 0);
            end else begin
               if (seq == rem_seq + 16'd1) begin
                  put(ACT_DELIVER, FT_DATA, seq, h, 0);
                  rem_seq = seq;
               end else put(ACT_DROP, FT_DATA, seq, h, 0);
               arm_ack();
            end
         end
         OP_RX_ACK: begin
            if (!flow_up || loc_ph == PH_NONE) put(ACT_DROP, FT_DATA, seq, h, 0);
            else if (loc_ph == PH_ERR) begin
               put(ACT_TX, FT_RST, 0, 0, 0);
               put(ACT_DROP, FT_DATA, seq, h, 0);
            end else if (seq_newer(seq, acked)) begin
               d = seq - acked;
               if (int'(d) > in_flight) put(ACT_DROP, FT_DATA, seq, h, 0);
               else begin
                  if (loc_ph == PH_SYN) loc_ph = PH_RDY;
                  timer_restart();
                  acked = seq;
                  head = (head + int'(d)) % RING;
                  in_flight -= int'(d);
                  launch();
               end
            end else go_back();
         end
         OP_RX_SYN: begin
            if (!flow_up) begin
               flow_open();
               rem_seq = seq; rem_ph = PH_RDY;
               put(ACT_TX, FT_ACK, seq, 0, 0);
            end else if (rem_ph == PH_NONE) begin
               rem_seq = seq; rem_ph = PH_RDY;
               put(ACT_TX, FT_ACK, seq, 0, 0);
            end else if ((rem_ph == PH_RDY || rem_ph == PH_FIN) &&
                         (rem_seq == seq || seq_newer(rem_seq, seq))) begin
               // duplicate syn, nothing to do
            end else put(ACT_TX, FT_RST, 0, 0, 0);
         end
         OP_RX_FIN: begin
            if (!flow_up) put(ACT_TX, FT_RST, 0, 0, 0);
            else begin
               if (seq == rem_seq + 16'd1) begin
                  rem_seq = seq; rem_ph = PH_FIN;
                  if (fs == FS_VALID) put(ACT_DELIVER, FT_FIN, seq, h, 1);
                  else put(ACT_DROP, FT_DATA, seq, h, 0);
               end else put(ACT_DROP, FT_DATA, seq, h, 0);
               arm_ack();
            end
         end
         OP_RX_RST: begin
            if (flow_up) begin
               loc_ph = PH_ERR; rem_ph = PH_ERR; in_flight = 0; queued = 0;
            end
            put(ACT_ERROR, FT_DATA, 0, 0, 0);
         end
         OP_TICK: begin
            fired = 0;
            if (ack_due) begin
               if (ack_elapsed < 16'hFFFF) ack_elapsed++;
               if (ack_elapsed >= adly_reg) begin
                  put(ACT_TX, FT_ACK, rem_seq, 0, 0);
                  ack_due = 0; fired = 1;
               end
            end
            // an ack sent on this tick pushes any due resend to the next one
            if (flow_up && loc_ph != PH_NONE && loc_ph != PH_ERR && in_flight > 0) begin
               if (relapsed != 32'hFFFF_FFFF) relapsed++;
               if (!fired && relapsed > rtimeout) begin
                  go_back();
                  relapsed = 0;
               end
            end
         end
         OP_STALE: begin
            if (flow_up && (loc_ph == PH_SYN || loc_ph == PH_RDY || rem_ph == PH_RDY)) begin
               put(ACT_TX, FT_RST, 0, 0, 0);
               loc_ph = PH_ERR; rem_ph = PH_ERR; in_flight = 0; queued = 0;
               ack_due = 0;
            end
         end
         default: ;   // unused opcodes are ignored
      endcase
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_q.size());
         $display("tb_go_back_n_arq_endpoint: done, errors");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(0, 99) >= 7);
   end

   // result check, one transaction per edge
   always @(posedge clock) begin
      outcome_t o;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (expected_q.size() == 0) begin
            errors++;
            $error("unexpected result: tuser %h tdata %h", rsp_tuser, rsp_tdata);
         end else begin
            o = expected_q.pop_front();
            if (rsp_tuser[1:0] !== o.r.act) begin
               errors++; $error("action: expected %0d, got %0d", o.r.act, rsp_tuser[1:0]);
            end
            if (rsp_tuser[4:2] !== o.r.ftype) begin
               errors++; $error("frame_type: expected %0d, got %0d", o.r.ftype, rsp_tuser[4:2]);
            end
            if (rsp_tdata[15:0] !== o.r.seq) begin
               errors++; $error("frame_seq: expected %h, got %h", o.r.seq, rsp_tdata[15:0]);
            end
            if (rsp_tdata[31:16] !== o.r.hdl) begin
               errors++; $error("frame_handle: expected %h, got %h", o.r.hdl, rsp_tdata[31:16]);
            end
            if (rsp_tdata[32] !== o.r.eos) begin
               errors++; $error("end_of_stream: expected %0d, got %0d", o.r.eos, rsp_tdata[32]);
            end
            if (rsp_tlast !== o.last) begin
               errors++; $error("last: expected %0d, got %0d", o.last, rsp_tlast);
            end
         end
      end
   end

   // one event transaction; a typed row replaces the model's single result
   task automatic push_event(logic [3:0] op, logic [15:0] seq, logic [15:0] h,
                             logic [1:0] fs, bit typed = 0, rslt_type want = '0);
      outcome_t o;
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, fs, h, seq};
      do @(posedge clock); while (!req_tready);
      endpoint_step(op, seq, h, fs);
      n_events++;
      if (typed) begin
         if (step_q.size() != 1) begin
            errors++; $error("typed row: model gives %0d results", step_q.size());
         end
         o.r = want; o.last = 1'b1;
         expected_q.push_back(o);
      end else begin
         foreach (step_q[i]) expected_q.push_back(step_q[i]);
      end
   endtask

   // drain everything, including events that leave no result, then stop
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WINDOW:     win_reg   = val[6:0];
         CSR_RETRY_LIM:  rlim_reg  = val[3:0];
         CSR_RETRY_BASE: rbase_reg = val;
         CSR_ACK_DELAY:  adly_reg  = val;
         CSR_INIT_SEQ:   iseq_reg  = val;
         default: ;
      endcase
   endtask

   task automatic setup(logic [6:0] w, logic [3:0] lim, logic [15:0] base,
                        logic [15:0] dly, logic [15:0] iseq);
      csr_write(CSR_WINDOW, 16'(w));
      csr_write(CSR_RETRY_LIM, 16'(lim));
      csr_write(CSR_RETRY_BASE, base);
      csr_write(CSR_ACK_DELAY, dly);
      csr_write(CSR_INIT_SEQ, iseq);
   endtask

   // mostly well-formed traffic built from the current flow state
   task automatic random_event();
      int r;
      logic [15:0] s, h;
      logic [1:0] fs;
      r = $urandom_range(0, 99);
      h = 16'($urandom);
      s = 16'($urandom);
      fs = ($urandom_range(0, 9) == 0) ? 2'($urandom) : FS_VALID;
      if (noisy && r < 40) begin
         push_event(4'($urandom), s, h, 2'($urandom));
      end else if (r < 30) push_event(OP_SEND_DATA, s, h, fs);
      else if (r < 32) push_event(OP_SEND_END, s, h, fs);
      else if (r < 50) begin
         if ($urandom_range(0, 9) != 0) s = acked + 16'($urandom_range(0, in_flight));
         push_event(OP_RX_ACK, s, h, fs);
      end else if (r < 66) begin
         if ($urandom_range(0, 4) != 0) s = rem_seq + 16'd1;
         push_event(OP_RX_DATA, s, h, fs);
      end else if (r < 67) push_event(OP_RX_FIN, rem_seq + 16'd1, h, fs);
      else if (r < 71) begin
         if ($urandom_range(0, 1) != 0) s = rem_seq - 16'($urandom_range(0, 3));
         push_event(OP_RX_SYN, s, h, fs);
      end else if (r < 97 || !noisy) push_event(OP_TICK, s, h, fs);
      else push_event(($urandom_range(0, 1) != 0) ? OP_STALE : OP_RX_RST, s, h, fs);
   endtask

   // ---------------------------------------------------------------- stimulus
   row_t rows [$];

   initial begin
      win_reg = WINDOW_RST; rlim_reg = RETRY_LIM_RST; rbase_reg = RETRY_BASE_RST;
      adly_reg = ACK_DELAY_RST; iseq_reg = INIT_SEQ_RST;
      flow_up = 0; loc_ph = PH_NONE; rem_ph = PH_NONE;
      next_seq = 0; acked = 0; rem_seq = 0; head = 0; in_flight = 0; queued = 0;
      rcount = 0; relapsed = 0; rtimeout = 0; ack_due = 0; ack_elapsed = 0;

      // directed rows: initial sequence just below the wrap, short timers
      rows = '{
         '{OP_SEND_END,  16'h1234, 16'hABCD, FS_VALID, 1,
           '{ACT_DROP, FT_DATA, 16'h1234, 16'hABCD, 1'b0}},   // end, no flow
         '{OP_RX_ACK,    16'hFFFF, 16'h0000, FS_VALID, 1,
           '{ACT_DROP, FT_DATA, 16'hFFFF, 16'h0000, 1'b0}},   // ack, no flow
         '{OP_RX_DATA,   16'h0000, 16'hFFFF, 2'd3,     1,
           '{ACT_DROP, FT_DATA, 16'h0000, 16'hFFFF, 1'b0}},
         '{OP_RX_FIN,    16'h0001, 16'h5555, FS_VALID, 1,
           '{ACT_TX, FT_RST, 16'h0000, 16'h0000, 1'b0}},      // fin, no flow
         '{OP_TICK,      16'h0000, 16'h0000, FS_VALID, 0, '0},
         '{4'd15,        16'hFFFF, 16'hFFFF, 2'd3,     0, '0}, // unused opcode
         '{OP_SEND_DATA, 16'h0000, 16'hFFFF, FS_VALID, 0, '0}, // opens with a syn
         '{OP_SEND_DATA, 16'hFFFF, 16'h0000, FS_VALID, 0, '0},
         '{OP_RX_ACK,    16'hFFFF, 16'h0001, FS_VALID, 0, '0}, // syn acked
         '{OP_RX_ACK,    16'hFFFF, 16'h0002, FS_VALID, 0, '0}, // duplicate, go back
         '{OP_RX_ACK,    16'h0005, 16'h0003, FS_VALID, 1,
           '{ACT_DROP, FT_DATA, 16'h0005, 16'h0003, 1'b0}},   // past the sent frames
         '{OP_RX_SYN,    16'h8000, 16'h0000, FS_VALID, 1,
           '{ACT_TX, FT_ACK, 16'h8000, 16'h0000, 1'b0}},
         '{OP_RX_DATA,   16'h8001, 16'h00AA, FS_VALID, 1,
           '{ACT_DELIVER, FT_DATA, 16'h8001, 16'h00AA, 1'b0}},
         '{OP_RX_DATA,   16'h8005, 16'h00BB, FS_VALID, 0, '0}, // out of order
         '{OP_RX_DATA,   16'h8002, 16'h00CC, FS_ENDED, 0, '0}, // rst and drop
         '{OP_TICK,      16'h0000, 16'h0000, FS_VALID, 0, '0},
         '{OP_TICK,      16'h0000, 16'h0000, FS_VALID, 0, '0},
         '{OP_TICK,      16'h0000, 16'h0000, FS_VALID, 0, '0},
         '{OP_RX_SYN,    16'h7000, 16'h0000, FS_VALID, 0, '0}, // old syn ignored
         '{OP_RX_SYN,    16'h9000, 16'h0000, FS_VALID, 0, '0}, // bad syn, rst
         '{OP_RX_FIN,    16'h8009, 16'h0000, FS_VALID, 0, '0}, // fin out of order
         '{OP_SEND_END,  16'h0000, 16'h0000, FS_VALID, 0, '0},
         '{OP_SEND_END,  16'h0000, 16'h7777, FS_VALID, 1,
           '{ACT_TX, FT_DATA, 16'h0000, 16'h7777, 1'b1}},     // forwarded end marker
         '{OP_RX_ACK,    16'h0002, 16'h0000, FS_VALID, 0, '0},
         '{OP_TICK,      16'h0000, 16'h0000, FS_VALID, 0, '0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      setup(7'd2, 4'd3, 16'd1, 16'd1, 16'hFFFE);
      foreach (rows[i])
         push_event(rows[i].op, rows[i].seq, rows[i].hdl, rows[i].fs,
                    rows[i].typed, rows[i].want);
      settle();

      // small window, short timers, retries run out often
      setup(7'd0, 4'd2, 16'd2, 16'd3, 16'h0000);
      repeat (60) random_event();
      settle();

      // widest window, slowest timers, no idling on either side
      calm = 1;
      setup(7'd127, 4'd15, 16'd65535, 16'd65535, 16'hFFFF);
      repeat (45) random_event();
      settle();
      calm = 0;

      // full window, a zero retry limit and noise with resets and stale notices
      noisy = 1;
      setup(7'd64, 4'd0, 16'd1, 16'd2, 16'h8000);
      repeat (35) random_event();
      settle();
      noisy = 0;

      // fail the flow, then queue sends until the ring overflows
      setup(7'd1, 4'd1, 16'd3, 16'd1, 16'h0001);
      push_event(OP_RX_FIN, rem_seq + 16'd1, 16'h4321, FS_VALID);
      push_event(OP_RX_RST, 16'h0000, 16'h0000, FS_VALID);
      repeat (RING + 4) push_event(OP_SEND_DATA, 16'($urandom), 16'($urandom), FS_VALID);
      push_event(OP_RX_ACK, 16'($urandom), 16'($urandom), FS_VALID);
      settle();

      $display("covered %0d events and %0d results over five register settings,",
               n_events, n_results);
      $display("including go-back resends, ring overflow and flow error paths");
      if (errors == 0) $display("tb_go_back_n_arq_endpoint: done, clean");
      else $display("tb_go_back_n_arq_endpoint: done, errors");
      $finish;
   end

endmodule

[filelist.f]
rtl/gbn_pkg.sv
rtl/gbn_ctrl.sv
rtl/gbn_dp.sv
rtl/go_back_n_arq_endpoint.sv
sim/tb_go_back_n_arq_endpoint.sv
